// ===== rtl/i2cmrt_pkg.sv =====
// Package for the I2C master register-transaction sequencer.
// Phase, engine operation, status and action codes; request and result records.
// No dependencies.
`timescale 1ns / 1ps

package i2cmrt_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_EVENT = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_WAIT_START  = 4'd1,
    PH_CHK_ADDR    = 4'd2,
    PH_CHK_CMD     = 4'd3,
    PH_CHK_FIRST   = 4'd4,
    PH_CHK_SECOND  = 4'd5,
    PH_WAIT_STOP   = 4'd6,
    PH_WAIT_RSTART = 4'd7,
    PH_WAIT_RADDR  = 4'd8,
    PH_RECV_FIRST  = 4'd9,
    PH_ACK_FIRST   = 4'd10,
    PH_RECV_SECOND = 4'd11,
    PH_NACK_SECOND = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_START  = 3'd1,
    OP_RSTART = 3'd2,
    OP_STOP   = 3'd3,
    OP_SEND   = 3'd4,
    OP_RCEN   = 3'd5,
    OP_ACK    = 3'd6,
    OP_NACK   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BUSY   = 3'd1,
    ST_NOK    = 3'd2,
    ST_NO_ADR = 3'd3,
    ST_NO_DAT = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] target_address;
    logic [7:0] command_byte;
    logic [7:0] write_first;
    logic [7:0] write_second;
    logic       start_seen;
    logic       stop_seen;
    logic       ack_missing;
    logic       write_collision;
    logic [7:0] received_byte;
  } req_t;

  typedef struct packed {
    op_t        engine_op;
    logic [7:0] tx_byte;
    logic       done_res;
    status_t    status;
    logic [7:0] read_first;
    logic [7:0] read_second;
  } rsp_t;

endpackage

// ===== rtl/i2cmrt_if.sv =====
// Valid/ready channel interfaces for requests and results of the sequencer.
// No dependencies.
`timescale 1ns / 1ps

interface i2cmrt_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] target_address;
  logic [7:0] command_byte;
  logic [7:0] write_first;
  logic [7:0] write_second;
  logic       start_seen;
  logic       stop_seen;
  logic       ack_missing;
  logic       write_collision;
  logic [7:0] received_byte;

  modport source (
    output valid, action, target_address, command_byte, write_first, write_second,
           start_seen, stop_seen, ack_missing, write_collision, received_byte,
    input  ready
  );
  modport sink (
    input  valid, action, target_address, command_byte, write_first, write_second,
           start_seen, stop_seen, ack_missing, write_collision, received_byte,
    output ready
  );
endinterface

interface i2cmrt_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] engine_op;
  logic [7:0] tx_byte;
  logic       done_res;
  logic [2:0] status;
  logic [7:0] read_first;
  logic [7:0] read_second;

  modport source (
    output valid, engine_op, tx_byte, done_res, status, read_first, read_second,
    input  ready
  );
  modport sink (
    input  valid, engine_op, tx_byte, done_res, status, read_first, read_second,
    output ready
  );
endinterface

// ===== rtl/i2cmrt_seq.sv =====
// Transaction state registers and per-request next-state/result logic.
// Depends on i2cmrt_pkg.
`timescale 1ns / 1ps

module i2cmrt_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  i2cmrt_pkg::req_t  req,
  output i2cmrt_pkg::rsp_t  rsp
);

  i2cmrt_pkg::phase_t  phase, phase_next;
  logic                is_read, is_read_next;
  logic                first_pass, first_pass_next;
  logic [6:0]          held_address, held_address_next;
  logic [7:0]          held_command, held_command_next;
  logic [7:0]          held_first, held_first_next;
  logic [7:0]          held_second, held_second_next;
  i2cmrt_pkg::status_t held_status, held_status_next;
  logic                bad_ack;
  logic                is_start;

  assign bad_ack  = req.ack_missing | req.write_collision;
  assign is_start = (req.action == i2cmrt_pkg::ACT_WRITE) ||
                    (req.action == i2cmrt_pkg::ACT_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= i2cmrt_pkg::PH_IDLE;
      is_read      <= 1'b0;
      first_pass   <= 1'b1;
      held_address <= '0;
      held_command <= '0;
      held_first   <= '0;
      held_second  <= '0;
      held_status  <= i2cmrt_pkg::ST_OK;
    end else if (accept) begin
      phase        <= phase_next;
      is_read      <= is_read_next;
      first_pass   <= first_pass_next;
      held_address <= held_address_next;
      held_command <= held_command_next;
      held_first   <= held_first_next;
      held_second  <= held_second_next;
      held_status  <= held_status_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    is_read_next      = is_read;
    first_pass_next   = first_pass;
    held_address_next = held_address;
    held_command_next = held_command;
    held_first_next   = held_first;
    held_second_next  = held_second;
    held_status_next  = held_status;
    rsp               = '0;

    if (is_start) begin
      if (phase != i2cmrt_pkg::PH_IDLE) begin
        rsp.done_res = 1'b1;
        rsp.status   = i2cmrt_pkg::ST_BUSY;
      end else begin
        is_read_next      = (req.action == i2cmrt_pkg::ACT_READ);
        held_address_next = req.target_address;
        held_command_next = req.command_byte;
        held_first_next   = is_read_next ? 8'd0 : req.write_first;
        held_second_next  = is_read_next ? 8'd0 : req.write_second;
        held_status_next  = i2cmrt_pkg::ST_OK;
        if (first_pass || (!req.start_seen && req.stop_seen)) begin
          first_pass_next = 1'b0;
          phase_next      = i2cmrt_pkg::PH_WAIT_START;
          rsp.engine_op   = i2cmrt_pkg::OP_START;
        end else begin
          rsp.done_res = 1'b1;
          rsp.status   = i2cmrt_pkg::ST_NOK;
        end
      end
    end else if (req.action == i2cmrt_pkg::ACT_EVENT) begin
      unique case (phase)
        i2cmrt_pkg::PH_IDLE: begin
        end
        i2cmrt_pkg::PH_WAIT_START: begin
          if (req.start_seen && !req.stop_seen) begin
            rsp.engine_op = i2cmrt_pkg::OP_SEND;
            rsp.tx_byte   = {held_address, 1'b0};
            phase_next    = i2cmrt_pkg::PH_CHK_ADDR;
          end else begin
            rsp.engine_op    = i2cmrt_pkg::OP_STOP;
            phase_next       = i2cmrt_pkg::PH_WAIT_STOP;
            held_status_next = is_read ? i2cmrt_pkg::ST_NO_ADR : i2cmrt_pkg::ST_NOK;
          end
        end
        i2cmrt_pkg::PH_CHK_ADDR: begin
          if (!bad_ack) begin
            rsp.engine_op = i2cmrt_pkg::OP_SEND;
            rsp.tx_byte   = held_command;
            phase_next    = i2cmrt_pkg::PH_CHK_CMD;
          end else begin
            rsp.engine_op    = i2cmrt_pkg::OP_STOP;
            phase_next       = i2cmrt_pkg::PH_WAIT_STOP;
            held_status_next = is_read ? i2cmrt_pkg::ST_NO_DAT : i2cmrt_pkg::ST_NO_ADR;
          end
        end
        i2cmrt_pkg::PH_CHK_CMD: begin
          if (bad_ack) begin
            rsp.engine_op    = i2cmrt_pkg::OP_STOP;
            phase_next       = i2cmrt_pkg::PH_WAIT_STOP;
            held_status_next = i2cmrt_pkg::ST_NO_DAT;
          end else if (is_read) begin
            rsp.engine_op = i2cmrt_pkg::OP_RSTART;
            phase_next    = i2cmrt_pkg::PH_WAIT_RSTART;
          end else begin
            rsp.engine_op = i2cmrt_pkg::OP_SEND;
            rsp.tx_byte   = held_first;
            phase_next    = i2cmrt_pkg::PH_CHK_FIRST;
          end
        end
        i2cmrt_pkg::PH_CHK_FIRST: begin
          if (!bad_ack) begin
            rsp.engine_op = i2cmrt_pkg::OP_SEND;
            rsp.tx_byte   = held_second;
            phase_next    = i2cmrt_pkg::PH_CHK_SECOND;
          end else begin
            rsp.engine_op    = i2cmrt_pkg::OP_STOP;
            phase_next       = i2cmrt_pkg::PH_WAIT_STOP;
            held_status_next = i2cmrt_pkg::ST_NO_DAT;
          end
        end
        i2cmrt_pkg::PH_CHK_SECOND: begin
          rsp.engine_op    = i2cmrt_pkg::OP_STOP;
          phase_next       = i2cmrt_pkg::PH_WAIT_STOP;
          held_status_next = bad_ack ? i2cmrt_pkg::ST_NO_DAT : held_status;
        end
        i2cmrt_pkg::PH_WAIT_RSTART: begin
          rsp.engine_op = i2cmrt_pkg::OP_SEND;
          rsp.tx_byte   = {held_address, 1'b1};
          phase_next    = i2cmrt_pkg::PH_WAIT_RADDR;
        end
        i2cmrt_pkg::PH_WAIT_RADDR: begin
          rsp.engine_op = i2cmrt_pkg::OP_RCEN;
          phase_next    = i2cmrt_pkg::PH_RECV_FIRST;
        end
        i2cmrt_pkg::PH_RECV_FIRST: begin
          held_first_next = req.received_byte;
          rsp.engine_op   = i2cmrt_pkg::OP_ACK;
          phase_next      = i2cmrt_pkg::PH_ACK_FIRST;
        end
        i2cmrt_pkg::PH_ACK_FIRST: begin
          rsp.engine_op = i2cmrt_pkg::OP_RCEN;
          phase_next    = i2cmrt_pkg::PH_RECV_SECOND;
        end
        i2cmrt_pkg::PH_RECV_SECOND: begin
          held_second_next = req.received_byte;
          rsp.engine_op    = i2cmrt_pkg::OP_NACK;
          phase_next       = i2cmrt_pkg::PH_NACK_SECOND;
        end
        i2cmrt_pkg::PH_NACK_SECOND: begin
          rsp.engine_op = i2cmrt_pkg::OP_STOP;
          phase_next    = i2cmrt_pkg::PH_WAIT_STOP;
        end
        i2cmrt_pkg::PH_WAIT_STOP: begin
          phase_next   = i2cmrt_pkg::PH_IDLE;
          rsp.done_res = 1'b1;
          rsp.status   = held_status;
          if (is_read) begin
            rsp.read_first  = held_first;
            rsp.read_second = held_second;
          end
        end
        default: begin
          phase_next = i2cmrt_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/i2cmrt_out_reg.sv =====
// Result register with valid/ready handshake toward the result channel.
// Depends on i2cmrt_pkg.
`timescale 1ns / 1ps

module i2cmrt_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  i2cmrt_pkg::rsp_t rsp_in,
  input  logic             take,
  output logic             valid,
  output logic             can_load,
  output i2cmrt_pkg::rsp_t rsp_out
);

  assign can_load = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_out <= rsp_in;
    end
  end

endmodule

// ===== rtl/i2c_master_register_transaction.sv =====
// I2C master register-transaction sequencer: one request in, one result out, one request per
// cycle while results are drained. A start request (write or read) taken while idle latches
// address, command and, for a write, data; each engine event request advances the sequence and
// names the next engine operation. The result of a request is registered and appears on the
// result channel the cycle after acceptance; a new request is taken in the same cycle as long as
// the result register is empty or being drained, so the result register's handshake alone sets
// the rate. Depends on i2cmrt_pkg, i2cmrt_if, i2cmrt_seq and i2cmrt_out_reg.
`timescale 1ns / 1ps

module i2c_master_register_transaction (
  input  logic  clk,
  input  logic  rst,
  i2cmrt_req_if.sink   request,
  i2cmrt_rsp_if.source result
);

  i2cmrt_pkg::req_t req;
  i2cmrt_pkg::rsp_t rsp_comb;
  i2cmrt_pkg::rsp_t rsp_reg;
  logic             accept;
  logic             can_load;

  assign req.action          = request.action;
  assign req.target_address  = request.target_address;
  assign req.command_byte    = request.command_byte;
  assign req.write_first     = request.write_first;
  assign req.write_second    = request.write_second;
  assign req.start_seen      = request.start_seen;
  assign req.stop_seen       = request.stop_seen;
  assign req.ack_missing     = request.ack_missing;
  assign req.write_collision = request.write_collision;
  assign req.received_byte   = request.received_byte;

  assign request.ready = can_load;
  assign accept        = request.valid && can_load;

  i2cmrt_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .rsp    (rsp_comb)
  );

  i2cmrt_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .rsp_in   (rsp_comb),
    .take     (result.ready),
    .valid    (result.valid),
    .can_load (can_load),
    .rsp_out  (rsp_reg)
  );

  assign result.engine_op   = rsp_reg.engine_op;
  assign result.tx_byte     = rsp_reg.tx_byte;
  assign result.done_res    = rsp_reg.done_res;
  assign result.status      = rsp_reg.status;
  assign result.read_first  = rsp_reg.read_first;
  assign result.read_second = rsp_reg.read_second;

  a_stall_blocks_request: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !request.ready)
    else $error("request taken while result stalled");

  a_done_no_op: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.done_res |-> result.engine_op == i2cmrt_pkg::OP_NONE)
    else $error("finished transaction also orders an engine operation");

  a_busy_status_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.done_res |-> result.status == i2cmrt_pkg::ST_OK)
    else $error("status set without done");

  a_tx_only_on_send: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.engine_op != i2cmrt_pkg::OP_SEND |-> result.tx_byte == 8'd0)
    else $error("tx byte set without send operation");

endmodule
